FILE: hdl/mccc_pkg.sv
// Package for the multi-channel click classifier.
// Holds the operation, phase and result codes, register indexes and the item type.
// No dependencies.
`default_nettype none

package mccc_pkg;

    typedef enum logic [1:0] {
        FUNC_PRESS   = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_POLL    = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        PH_IDLE         = 2'd0,
        PH_WAIT_RELEASE = 2'd1,
        PH_WAIT_PRESS   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_SINGLE = 2'd1,
        KIND_DOUBLE = 2'd2,
        KIND_LONG   = 2'd3
    } kind_t;

    localparam logic REG_DOUBLE_GAP = 1'b0;
    localparam logic REG_LONG_PRESS = 1'b1;

    localparam logic [15:0] DOUBLE_GAP_RESET = 16'd250;
    localparam logic [15:0] LONG_PRESS_RESET = 16'd800;

    localparam logic [1:0] COUNT_MAX = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  channel;
        logic [31:0] now_ms;
    } item_t;

endpackage

`default_nettype wire

FILE: hdl/multi_channel_click_classifier.sv
// Top level of the multi-channel click classifier: stream handshakes and registers.
// Depends on mccc_pkg and mccc_chan.
//
//   Channel  | Direction | Handshake                    | Payload
//   s_axis   | in        | s_axis_tvalid/s_axis_tready  | tdata: channel, now_ms; tuser: func
//   m_axis   | out       | m_axis_tvalid/m_axis_tready  | tdata: out_channel; tuser: click_kind
//   cfg      | in        | cfg_valid/cfg_ready          | cfg_index, cfg_data
//
// Unless stalled, one item per cycle enters the input register, then the result register.
// The input register and the result register each hold one item, so one more item is
// taken while a result waits; with both full and the result held, the input stalls.
// Channel state is read combinationally and written as the item moves to the result register.
// Reset restores every channel to idle and both thresholds to their defaults.
`default_nettype none

module multi_channel_click_classifier
    import mccc_pkg::*;
#(
    parameter int CHANNELS = 14
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // channel[3:0], now_ms[35:4], zero fill
    input  wire logic [1:0]  s_axis_tuser,   // func[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // out_channel[3:0], zero fill
    output logic [1:0]       m_axis_tuser,   // click_kind[1:0]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic        in_valid_reg;
    item_t       in_item_reg;
    logic        out_valid_reg;
    logic [3:0]  out_channel_reg;
    kind_t       out_kind_reg;
    logic [15:0] double_gap_reg;
    logic [15:0] long_press_reg;

    logic  advance;
    logic  accept;
    kind_t kind;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    mccc_chan #(
        .CHANNELS(CHANNELS)
    ) u_chan (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (in_item_reg),
        .commit       (advance),
        .double_gap_ms(double_gap_reg),
        .long_press_ms(long_press_reg),
        .kind         (kind)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg.func    <= s_axis_tuser;
            in_item_reg.channel <= s_axis_tdata[3:0];
            in_item_reg.now_ms  <= s_axis_tdata[35:4];
        end
        if (advance)
        begin
            out_channel_reg <= in_item_reg.channel;
            out_kind_reg    <= kind;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            double_gap_reg <= DOUBLE_GAP_RESET;
            long_press_reg <= LONG_PRESS_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DOUBLE_GAP: double_gap_reg <= cfg_data;
                REG_LONG_PRESS: long_press_reg <= cfg_data;
                default:        double_gap_reg <= double_gap_reg;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_channel_reg};
    assign m_axis_tuser  = out_kind_reg;

endmodule

`default_nettype wire

FILE: hdl/mccc_chan.sv
// Per-channel gesture state and the classification of one item.
// Depends on mccc_pkg.
`default_nettype none

module mccc_chan
    import mccc_pkg::*;
#(
    parameter int CHANNELS = 14
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire item_t       req,
    input  wire logic        commit,
    input  wire logic [15:0] double_gap_ms,
    input  wire logic [15:0] long_press_ms,
    output kind_t            kind
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [6:0] CH_LIMIT = 7'(CHANNELS);

    phase_t      phase_reg [CHANNELS];
    logic [31:0] time_reg  [CHANNELS];
    logic [1:0]  count_reg [CHANNELS];

    logic [IDX_W-1:0] idx;
    logic             in_range;
    phase_t           phase_cur;
    logic [31:0]      time_cur;
    logic [1:0]       count_cur;
    logic [31:0]      elapsed;
    phase_t           phase_next;
    logic [31:0]      time_next;
    logic [1:0]       count_next;

    assign idx      = IDX_W'(req.channel);
    assign in_range = {3'b000, req.channel} < CH_LIMIT;

    always_comb
    begin
        if (in_range)
        begin
            phase_cur = phase_reg[idx];
            time_cur  = time_reg[idx];
            count_cur = count_reg[idx];
        end
        else
        begin
            phase_cur = PH_IDLE;
            time_cur  = '0;
            count_cur = '0;
        end
    end

    assign elapsed = req.now_ms - time_cur;

    always_comb
    begin
        phase_next = phase_cur;
        time_next  = time_cur;
        count_next = count_cur;
        kind       = KIND_NONE;
        if (in_range)
        begin
            case (req.func)
                FUNC_PRESS:
                begin
                    phase_next = PH_WAIT_RELEASE;
                    time_next  = req.now_ms;
                end
                FUNC_RELEASE:
                begin
                    if (phase_cur == PH_WAIT_RELEASE)
                    begin
                        phase_next = PH_WAIT_PRESS;
                        time_next  = req.now_ms;
                        if (count_cur != COUNT_MAX)
                        begin
                            count_next = count_cur + 2'd1;
                        end
                    end
                end
                FUNC_POLL:
                begin
                    if (phase_cur == PH_WAIT_PRESS)
                    begin
                        if (elapsed >= {16'd0, double_gap_ms})
                        begin
                            phase_next = PH_IDLE;
                            count_next = '0;
                            if (count_cur == 2'd1)
                            begin
                                kind = KIND_SINGLE;
                            end
                            else if (count_cur != 2'd0)
                            begin
                                kind = KIND_DOUBLE;
                            end
                        end
                    end
                    else if (phase_cur == PH_WAIT_RELEASE)
                    begin
                        if (elapsed >= {16'd0, long_press_ms})
                        begin
                            phase_next = PH_IDLE;
                            count_next = '0;
                            kind       = KIND_LONG;
                        end
                    end
                end
                default:
                begin
                    kind = KIND_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                phase_reg[i] <= PH_IDLE;
                time_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else if (commit && in_range)
        begin
            phase_reg[idx] <= phase_next;
            time_reg[idx]  <= time_next;
            count_reg[idx] <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/mccc_checker.sv
// Port-level checks for the multi-channel click classifier, bound to the top level.
// Depends on mccc_pkg.
`default_nettype none

module mccc_checker
    import mccc_pkg::*;
#(
    parameter int CHANNELS = 14
)
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [7:0]  m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready
);

    localparam logic [6:0] CH_LIMIT = 7'(CHANNELS);

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("Result shown during reset.");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("Input stalled with an empty result register.");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |-> ##2 m_axis_tvalid)
        else $error("Accepted item produced no result.");

    a_report_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != KIND_NONE) |-> ({3'b000, m_axis_tdata[3:0]} < CH_LIMIT))
        else $error("Gesture reported on a channel that does not exist.");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("Stalled result changed.");

endmodule

bind multi_channel_click_classifier mccc_checker #(
    .CHANNELS(CHANNELS)
) u_mccc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
);

`default_nettype wire

FILE: tb/tb_multi_channel_click_classifier.sv
// Self-checking testbench for multi_channel_click_classifier: press, release and poll
// items go in on the input stream and each click verdict is checked against a scoreboard.
// Depends on mccc_pkg and the classifier RTL.

module tb_multi_channel_click_classifier;

    timeunit 1ns;
    timeprecision 1ps;

    import mccc_pkg::*;

    localparam int CHANNELS = 14;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int PHASE_ITEMS = 230;
    localparam int PHASE_COUNT = 7;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [3:0] channel;
        kind_t      kind;
    } click_result_t;

    class ClickScoreboard;
        phase_t        phase [CHANNELS];
        logic [31:0]   stamp [CHANNELS];
        logic [1:0]    clicks [CHANNELS];
        logic [15:0]   gap_ms;
        logic [15:0]   hold_ms;
        click_result_t expected_results [$];
        int            errors;
        int            checked;
        int            kind_tally [4];

        function new();
            foreach (phase[i])
            begin
                phase[i] = PH_IDLE;
                stamp[i] = '0;
                clicks[i] = '0;
            end
            foreach (kind_tally[k])
                kind_tally[k] = 0;
            gap_ms = DOUBLE_GAP_RESET;
            hold_ms = LONG_PRESS_RESET;
            errors = 0;
            checked = 0;
        endfunction

        function void set_threshold(logic idx, logic [15:0] value);
            if (idx == REG_DOUBLE_GAP)
                gap_ms = value;
            else
                hold_ms = value;
        endfunction

        function void note_input(logic [1:0] op, logic [3:0] ch, logic [31:0] now_ms);
            kind_t         verdict;
            logic [31:0]   elapsed;
            click_result_t entry;
            verdict = KIND_NONE;
            if (ch < CHANNELS)
            begin
                elapsed = now_ms - stamp[ch];
                case (op)
                    FUNC_PRESS:
                    begin
                        phase[ch] = PH_WAIT_RELEASE;
                        stamp[ch] = now_ms;
                    end
                    FUNC_RELEASE:
                    begin
                        if (phase[ch] == PH_WAIT_RELEASE)
                        begin
                            phase[ch] = PH_WAIT_PRESS;
                            stamp[ch] = now_ms;
                            if (clicks[ch] != COUNT_MAX)
                                clicks[ch] = clicks[ch] + 2'd1;
                        end
                    end
                    FUNC_POLL:
                    begin
                        if (phase[ch] == PH_WAIT_PRESS && elapsed >= {16'd0, gap_ms})
                        begin
                            phase[ch] = PH_IDLE;
                            if (clicks[ch] != 2'd0)
                            begin
                                if (clicks[ch] == 2'd1)
                                    verdict = KIND_SINGLE;
                                else
                                    verdict = KIND_DOUBLE;
                                clicks[ch] = 2'd0;
                            end
                        end
                        else if (phase[ch] == PH_WAIT_RELEASE && elapsed >= {16'd0, hold_ms})
                        begin
                            phase[ch] = PH_IDLE;
                            clicks[ch] = 2'd0;
                            verdict = KIND_LONG;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            entry.channel = ch;
            entry.kind = verdict;
            expected_results.insert(expected_results.size(), entry);
        endfunction

        function void check_result(logic [3:0] ch, logic [1:0] kind);
            click_result_t want;
            if (expected_results.size() == 0)
            begin
                $error("Result for channel %0d, kind %0d, with no item waiting for it", ch, kind);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            checked++;
            kind_tally[want.kind]++;
            if (ch !== want.channel)
            begin
                $error("out_channel mismatch: expected %0d, actual %0d", want.channel, ch);
                errors++;
            end
            if (kind !== want.kind)
            begin
                $error("click_kind mismatch: expected %0d, actual %0d", want.kind, kind);
                errors++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b1;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = FUNC_PRESS;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = REG_DOUBLE_GAP;
    logic [15:0] cfg_data = '0;

    ClickScoreboard sb = new();

    logic [31:0] wall_ms = '0;
    logic [15:0] cur_gap = DOUBLE_GAP_RESET;
    logic [15:0] cur_hold = LONG_PRESS_RESET;
    logic [15:0] gap_plan [PHASE_COUNT];
    logic [15:0] hold_plan [PHASE_COUNT];
    bit          quiet = 1'b0;
    int          holdoffs_asked = 0;
    int          holdoffs_done = 0;
    int          items_sent = 0;
    int          cycle_count = 0;

    multi_channel_click_classifier #(
        .CHANNELS(CHANNELS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $error("Run timed out after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[3:0], m_axis_tuser);
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (holdoffs_done < holdoffs_asked)
            begin
                holdoffs_done++;
                m_axis_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
            end
            m_axis_tready <= quiet || ($urandom_range(0, 99) >= 7);
        end
    end

    task automatic send_item(logic [1:0] op, logic [3:0] ch, logic [31:0] now_ms);
        while (!quiet && $urandom_range(0, 99) < 7)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'd0, now_ms, ch};
        s_axis_tuser <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_input(op, ch, now_ms);
        if (op != FUNC_UNUSED && ch < CHANNELS)
            items_sent++;
    endtask

    task automatic offer_item(logic [1:0] op, logic [3:0] ch);
        if ($urandom_range(0, 9) == 0)
            send_item(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), $urandom());
        send_item(op, ch, wall_ms);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_thresholds(logic [15:0] gap, logic [15:0] hold);
        cfg_valid <= 1'b1;
        cfg_index <= REG_DOUBLE_GAP;
        cfg_data <= gap;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_threshold(REG_DOUBLE_GAP, gap);
        cfg_index <= REG_LONG_PRESS;
        cfg_data <= hold;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_threshold(REG_LONG_PRESS, hold);
        cfg_valid <= 1'b0;
        cur_gap = gap;
        cur_hold = hold;
    endtask

    function automatic logic [31:0] short_of(logic [15:0] limit);
        if (limit == 16'd0)
            return 32'd0;
        return $urandom_range(0, limit - 1);
    endfunction

    function automatic logic [31:0] around(logic [15:0] limit);
        case ($urandom_range(0, 7))
            0, 1, 2: return short_of(limit);
            3: return {16'd0, limit};
            7: return $urandom();
            default: return limit + $urandom_range(1, 40);
        endcase
    endfunction

    task automatic play_gesture();
        logic [3:0] ch;
        int         presses;
        ch = 4'($urandom_range(0, CHANNELS - 1));
        if ($urandom_range(0, 3) == 0)
        begin
            offer_item(FUNC_PRESS, ch);
            wall_ms += around(cur_hold);
            offer_item(FUNC_POLL, ch);
            if ($urandom_range(0, 1) == 0)
            begin
                wall_ms += around(cur_hold);
                offer_item(FUNC_POLL, ch);
            end
            wall_ms += short_of(cur_hold);
            offer_item(FUNC_RELEASE, ch);
            wall_ms += around(cur_gap);
            offer_item(FUNC_POLL, ch);
        end
        else
        begin
            presses = $urandom_range(1, 4);
            repeat (presses)
            begin
                offer_item(FUNC_PRESS, ch);
                wall_ms += short_of(cur_hold);
                offer_item(FUNC_RELEASE, ch);
                wall_ms += short_of(cur_gap);
                if ($urandom_range(0, 3) == 0)
                    offer_item(FUNC_POLL, ch);
            end
            wall_ms += around(cur_gap);
            offer_item(FUNC_POLL, ch);
            if ($urandom_range(0, 2) == 0)
            begin
                wall_ms += around(cur_gap);
                offer_item(FUNC_POLL, ch);
            end
        end
    endtask

    initial
    begin
        int target;
        rst_n <= 1'b0;
        gap_plan = '{16'd1, 16'd65535, 16'd40, 16'd300, 16'd0, 16'd65535, 16'd1};
        hold_plan = '{16'd1, 16'd65535, 16'd120, 16'd90, 16'd65535, 16'd0, 16'd1};
        gap_plan[PHASE_COUNT - 1] = 16'($urandom_range(2, 500));
        hold_plan[PHASE_COUNT - 1] = 16'($urandom_range(2, 500));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Default thresholds out of reset: long press, a single click across the
        // time wrap, a saturated click burst, a stray release and ignored items.
        send_item(FUNC_POLL, 4'd0, 32'd0);
        send_item(FUNC_PRESS, 4'd0, 32'd100);
        send_item(FUNC_POLL, 4'd0, 32'd899);
        send_item(FUNC_POLL, 4'd0, 32'd900);
        send_item(FUNC_PRESS, 4'd1, 32'hFFFF_FF00);
        send_item(FUNC_RELEASE, 4'd1, 32'hFFFF_FF10);
        send_item(FUNC_POLL, 4'd1, 32'h0000_0009);
        send_item(FUNC_POLL, 4'd1, 32'h0000_000A);
        for (int k = 0; k < 4; k++)
        begin
            send_item(FUNC_PRESS, 4'd13, 32'd1000 + 32'(20 * k));
            send_item(FUNC_RELEASE, 4'd13, 32'd1010 + 32'(20 * k));
        end
        send_item(FUNC_POLL, 4'd13, 32'd1320);
        send_item(FUNC_RELEASE, 4'd2, 32'd5);
        send_item(FUNC_POLL, 4'd2, 32'd2000);
        send_item(FUNC_UNUSED, 4'd3, 32'hFFFF_FFFF);
        send_item(FUNC_PRESS, 4'd14, 32'd0);
        send_item(FUNC_POLL, 4'd15, 32'hFFFF_FFFF);
        send_item(FUNC_POLL, 4'd0, 32'd5000);
        drain_results();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            set_thresholds(gap_plan[p], hold_plan[p]);
            wall_ms = (p == 0) ? 32'hFFFF_F000 : $urandom();
            quiet = (p == 2);
            if (p == 3)
                holdoffs_asked++;
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
                play_gesture();
            drain_results();
        end
        quiet = 1'b0;

        repeat (10) @(posedge clk);
        $display("Checked %0d results from %0d items over %0d threshold settings.",
                 sb.checked, items_sent, PHASE_COUNT + 1);
        $display("Reports seen: %0d single, %0d double, %0d long press.",
                 sb.kind_tally[KIND_SINGLE], sb.kind_tally[KIND_DOUBLE],
                 sb.kind_tally[KIND_LONG]);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
